>>> rtl/core/sdt_pkg.sv
`timescale 1ns / 1ps

package sdt_pkg;

  localparam int MaxDefects = 1024;
  localparam int IdxW       = $clog2(MaxDefects);
  localparam int CntW       = $clog2(MaxDefects + 1);
  localparam int OutCntW    = 11;
  localparam int EntryW     = 160;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_VERIFY = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] cylinder;
    logic signed [31:0] head_number;
    logic signed [31:0] bit_from_index;
    logic signed [31:0] bit_count;
    logic signed [31:0] sector_number;
    logic [31:0]        expected_sum;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] insert_index;
    logic [10:0] entry_total;
    logic [31:0] running_sum;
  } out_item_t;

  // One stored entry: cylinder, head, bfi, bit count, sector.
  typedef struct packed {
    logic [31:0] cyl;
    logic [31:0] head;
    logic [31:0] bfi;
    logic [31:0] nbits;
    logic [31:0] sect;
  } entry_t;

  // Compare result of the new defect against one stored entry.
  typedef struct packed {
    logic stop;
  } cmp_t;

endpackage

>>> rtl/core/sdt_ram.sv
`timescale 1ns / 1ps

module sdt_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sdt_cmp.sv
`timescale 1ns / 1ps

module sdt_cmp
  import sdt_pkg::*;
(
  input  entry_t      stored,
  input  entry_t      fresh,
  input  logic [31:0] unknown_marker,
  output cmp_t        res
);

  logic cyl_lt, head_lt, bfi_lt;

  // Signed cylinder, head, bfi ordering; a logical-sector entry stops the scan.
  always_comb begin
    cyl_lt  = $signed(fresh.cyl) < $signed(stored.cyl);
    head_lt = $signed(fresh.head) < $signed(stored.head);
    bfi_lt  = $signed(fresh.bfi) < $signed(stored.bfi);
    res.stop = (stored.bfi == unknown_marker) || cyl_lt ||
               ((fresh.cyl == stored.cyl) &&
                (head_lt || ((fresh.head == stored.head) && bfi_lt)));
  end

endmodule

>>> rtl/core/sorted_defect_table_insert_core.sv
`timescale 1ns / 1ps

// Sorted defect table with a running XOR checksum.
// Channels: in_valid/in_ready carries one in_item_t operation, out_valid/
// out_ready returns one out_item_t result per operation, and cfg_valid/
// cfg_ready writes the unknown-bfi marker (only while the block is idle;
// a pending configuration transfer takes priority over an input transfer).
// The table lives in one RAM with a single read and a single write port.
// Verify, clear and a refused insert present the result in the cycle
// after the input transfer; an append passes through the place state first.
// A sorted insert with n stored entries that lands in slot s scans entries
// 0 to s, one RAM read per cycle, then moves every later entry down one
// slot with a read state followed by a write state for each entry.
// in_ready is low while an operation is in flight and while the result
// waits; a stalled receiver simply holds the block in the result state with
// the result unchanged. Reset empties the table (count and checksum to
// zero) and sets the marker to all ones; the RAM itself is not cleared
// because only data from filled slots is ever used.
module sorted_defect_table_insert_core
  import sdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_PLACE, S_DONE
  } state_t;

  state_t         state;
  in_item_t       item;
  entry_t         fresh;
  logic [CntW-1:0] count;
  logic [31:0]    xsum;
  logic [31:0]    unknown_marker;
  logic [CntW-1:0] ptr;
  logic [CntW-1:0] slot;
  out_item_t      result;

  logic           we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t         wdata, rdata;
  cmp_t           cmp;

  assign fresh = '{cyl: item.cylinder, head: item.head_number,
                   bfi: item.bit_from_index, nbits: item.bit_count,
                   sect: item.sector_number};

  sdt_ram #(.Width(EntryW), .Depth(MaxDefects)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sdt_cmp u_cmp (
    .stored         (rdata),
    .fresh          (fresh),
    .unknown_marker (unknown_marker),
    .res            (cmp)
  );

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_data  = result;

  // RAM: scan reads ptr, shift reads ptr-1/writes ptr, place writes slot.
  always_comb begin
    we    = 1'b0;
    waddr = ptr[IdxW-1:0];
    wdata = rdata;
    raddr = ptr[IdxW-1:0];
    unique case (state)
      S_SHIFT_RD: raddr = IdxW'(ptr - 1'b1);
      S_SHIFT_WR: we = 1'b1;
      S_PLACE: begin
        we    = 1'b1;
        waddr = slot[IdxW-1:0];
        wdata = fresh;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      xsum           <= '0;
      unknown_marker <= '1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unknown_marker <= cfg_data;
          end else if (in_valid) begin
            item <= in_data;
            ptr  <= '0;
            unique case (op_t'(in_data.op))
              OP_INSERT, OP_APPEND: begin
                if (count == CntW'(MaxDefects)) begin
                  result <= '{status: ST_FULL, insert_index: '0,
                              entry_total: OutCntW'(count), running_sum: xsum};
                  state  <= S_DONE;
                end else if (in_data.op == OP_APPEND ||
                             in_data.bit_from_index == unknown_marker ||
                             count == '0) begin
                  slot  <= count;
                  state <= S_PLACE;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_VERIFY: begin
                result <= '{status: (xsum != in_data.expected_sum) ? ST_MISMATCH : ST_OK,
                            insert_index: '0, entry_total: OutCntW'(count),
                            running_sum: xsum};
                state  <= S_DONE;
              end
              OP_CLEAR: begin
                count  <= '0;
                xsum   <= '0;
                result <= '{status: ST_OK, insert_index: '0,
                            entry_total: '0, running_sum: '0};
                state  <= S_DONE;
              end
            endcase
          end
        end
        // rdata holds entry ptr-1 from the registered RAM read.
        S_SCAN: begin
          if (ptr != '0 && cmp.stop) begin
            slot  <= CntW'(ptr - 1'b1);
            ptr   <= count;
            state <= (count == CntW'(ptr - 1'b1)) ? S_PLACE : S_SHIFT_RD;
          end else if (ptr == count) begin
            slot  <= count;
            state <= S_PLACE;
          end else begin
            ptr <= CntW'(ptr + 1'b1);
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          ptr   <= CntW'(ptr - 1'b1);
          state <= (CntW'(ptr - 1'b1) == slot) ? S_PLACE : S_SHIFT_RD;
        end
        S_PLACE: begin
          count  <= CntW'(count + 1'b1);
          xsum   <= xsum ^ fresh.cyl ^ fresh.head ^ fresh.bfi ^ fresh.nbits ^
                    fresh.sect;
          result <= '{status: ST_OK, insert_index: OutCntW'(slot),
                      entry_total: OutCntW'(count + 1'b1),
                      running_sum: xsum ^ fresh.cyl ^ fresh.head ^ fresh.bfi ^
                                   fresh.nbits ^ fresh.sect};
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
